### rtl/stee_pkg.sv
// Shared types and codes for the schedule table expiry engine.
// No dependencies; used by all modules in rtl/.
package stee_pkg;

    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_START_REL  = 3'd1,
        MODE_START_ABS  = 3'd2,
        MODE_STOP       = 3'd3,
        MODE_NEXT       = 3'd4,
        MODE_STATUS     = 3'd5,
        MODE_LOAD_POINT = 3'd6,
        MODE_LOAD_TABLE = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_NEXT    = 2'd1,
        ST_RUNNING = 2'd2
    } run_state_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_ID    = 3'd1,
        STAT_BAD_VALUE = 3'd2,
        STAT_BAD_STATE = 3'd3,
        STAT_NO_FUNC   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_CMD       = 2'd0,
        KIND_POINT     = 2'd1,
        KIND_TICK_DONE = 2'd2
    } kind_t;

    localparam logic CFG_COUNTER_MAX = 1'b0;
    localparam logic CFG_EXT_CHECKS  = 1'b1;

    localparam int SUM_W = 18;   // widest counter sum: three 16-bit terms
    localparam int CNT_W = 16;

endpackage

### rtl/stee_modred.sv
// Bit-serial modulo reducer: result = value mod modulus, one bit per cycle.
// Depends on stee_pkg.
module stee_modred
    import stee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   value,
    input  logic [CNT_W:0]     modulus,
    output logic               done,
    output logic [CNT_W-1:0]   result
);

    localparam int CW = $clog2(SUM_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CW-1:0]      cnt_reg;
    logic [SUM_W-1:0]   sh_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic [CNT_W-1:0]   rem_next;

    assign trial    = {rem_reg, sh_reg[SUM_W-1]};
    assign diff     = trial - modulus;
    // remainder stays below modulus <= 2^CNT_W
    assign rem_next = (trial >= modulus) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= value;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[SUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

### rtl/schedule_table_expiry_engine.sv
// Top level of the schedule table expiry engine.
// Depends on stee_pkg and stee_modred.
//
// Usage:
//  - Command channel: an item is taken on a clock edge with start high and
//    busy low. mode selects tick, start (relative/absolute), stop, chain,
//    status, load_point or load_table.
//  - Results leave on result_valid, one per cycle, with no backpressure.
//    A command gives one result; a tick gives one point result per firing
//    table in ascending id order, then a tick-done result with last set.
//  - Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
//    write only while busy is low.
// Sequencing:
//  - Commands: a read of the table's first offset, then execute; a start
//    also runs the bit-serial modulo reduction of the expiry sum.
//  - Tick: a scan of the NUM_TABLES tables; each firing table takes three
//    offset memory reads and, unless it stops, the bit-serial modulo.
//  - Point offsets live in one synchronous RAM; per-table state is in flops.
// Reset: all tables stopped, one point each, links clear; offsets undefined
// until loaded. counter_max = 65535, extended checks on.
module schedule_table_expiry_engine
    import stee_pkg::*;
#(
    parameter int NUM_TABLES = 8,
    parameter int MAX_POINTS = 16,
    parameter int TICK_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [3:0]  table_id,
    input  logic [3:0]  other_table,
    input  logic [15:0] value,
    input  logic [3:0]  point_index,
    input  logic [4:0]  point_count,
    input  logic        repeat_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [2:0]  status,
    output logic [3:0]  result_table,
    output logic [3:0]  result_point,
    output logic [1:0]  table_state,
    output logic        last
);

    localparam int DEPTH = NUM_TABLES * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int UW    = $clog2(NUM_TABLES + 1);
    localparam logic [15:0] TMASK =
        (TICK_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << TICK_BITS) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_CMD_RD, S_CMD_EXEC, S_SCAN, S_RD_A, S_RD_B, S_RD_C,
        S_MOD_WAIT, S_EMIT
    } fsm_t;

    fsm_t               state_reg;
    logic [2:0]         mode_reg;
    logic [3:0]         tid_reg;
    logic [3:0]         oth_reg;
    logic [15:0]        val_reg;
    logic [3:0]         pidx_reg;
    logic [4:0]         pcnt_reg;
    logic               rep_reg;
    logic [15:0]        now_reg;
    logic [15:0]        cmax_reg;
    logic               ext_reg;
    logic [UW-1:0]      u_reg;
    logic [4:0]         i_reg;
    logic [4:0]         n_reg;
    logic [15:0]        offa_reg;
    logic [TW-1:0]      target_reg;
    logic               fire_reg;
    logic               tick_reg;
    logic               mod_start_reg;
    logic [SUM_W-1:0]   mod_val_reg;

    // per-table state
    logic [1:0]         run_reg  [NUM_TABLES];
    logic [4:0]         cp_reg   [NUM_TABLES];
    logic [4:0]         pc_reg   [NUM_TABLES];
    logic [15:0]        dur_reg  [NUM_TABLES];
    logic               rpt_reg  [NUM_TABLES];
    logic [15:0]        exp_reg  [NUM_TABLES];
    logic [TW-1:0]      link_reg [NUM_TABLES];
    logic               nv_reg   [NUM_TABLES];

    // point offset RAM
    logic [15:0]        mem [DEPTH];
    logic [15:0]        rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;

    // result registers
    logic               rv_reg;
    logic [1:0]         kind_reg;
    logic [2:0]         status_reg;
    logic [3:0]         rtab_reg;
    logic [3:0]         rpt_out_reg;
    logic [1:0]         ts_reg;
    logic               last_reg;

    logic               mod_done;
    logic [15:0]        mod_res;

    logic [TW-1:0]      tix;
    logic [TW-1:0]      oix;
    logic [TW-1:0]      uix;
    logic               chain_ok;
    logic [TW-1:0]      chain_src;
    logic [16:0]        modulus;
    logic [15:0]        delta;
    logic [15:0]        fin;
    logic [4:0]         i_inc;
    logic               id_bad;

    function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t,
                                              input logic [3:0] i);
        addr_of = AW'(32'(t) * MAX_POINTS + 32'(i));
    endfunction

    assign tix       = tid_reg[TW-1:0];
    assign oix       = oth_reg[TW-1:0];
    assign uix       = u_reg[TW-1:0];
    assign modulus   = {1'b0, cmax_reg} + 17'd1;
    assign i_inc     = i_reg + 5'd1;
    assign delta     = (rd_data_reg - offa_reg) & TMASK;
    assign fin       = (dur_reg[uix] - offa_reg) & TMASK;
    assign chain_ok  = nv_reg[uix] && (run_reg[link_reg[uix]] == ST_NEXT);
    assign chain_src = chain_ok ? link_reg[uix] : uix;
    assign id_bad    = ({1'b0, tid_reg} >= 5'(NUM_TABLES)) ||
                       ((mode_reg == MODE_NEXT) &&
                        ({1'b0, oth_reg} >= 5'(NUM_TABLES)));

    always_comb
    begin
        unique case (state_reg)
            S_CMD_RD: rd_addr = addr_of(tix, 4'd0);
            S_SCAN:   rd_addr = addr_of(uix, cp_reg[uix][3:0]);
            S_RD_A:   rd_addr = addr_of(uix, i_inc[3:0]);
            S_RD_B:   rd_addr = addr_of(chain_src, 4'd0);
            default:  rd_addr = '0;
        endcase
    end

    assign wr_en = (state_reg == S_CMD_EXEC) && !id_bad &&
                   (mode_reg == MODE_LOAD_POINT) &&
                   ({1'b0, pidx_reg} < 5'(MAX_POINTS)) &&
                   (run_reg[tix] == ST_STOPPED);
    assign wr_addr = addr_of(tix, pidx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= val_reg & TMASK;
        end
        rd_data_reg <= mem[rd_addr];
    end

    stee_modred u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start_reg),
        .value   (mod_val_reg),
        .modulus (modulus),
        .done    (mod_done),
        .result  (mod_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmax_reg      <= 16'hFFFF;
            ext_reg       <= 1'b1;
            now_reg       <= '0;
            u_reg         <= '0;
            mod_start_reg <= 1'b0;
            rv_reg        <= 1'b0;
            for (int k = 0; k < NUM_TABLES; k++)
            begin
                run_reg[k] <= ST_STOPPED;
                cp_reg[k]  <= '0;
                pc_reg[k]  <= 5'd1;
                dur_reg[k] <= '0;
                rpt_reg[k] <= 1'b0;
                exp_reg[k] <= '0;
                link_reg[k] <= '0;
                nv_reg[k]  <= 1'b0;
            end
        end
        else
        begin
            rv_reg        <= 1'b0;
            mod_start_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_COUNTER_MAX: cmax_reg <= cfg_data;
                    CFG_EXT_CHECKS:  ext_reg  <= cfg_data[0];
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        tid_reg  <= table_id;
                        oth_reg  <= other_table;
                        val_reg  <= value;
                        pidx_reg <= point_index;
                        pcnt_reg <= point_count;
                        rep_reg  <= repeat_flag;
                        if (mode == MODE_TICK)
                        begin
                            now_reg   <= value & TMASK;
                            u_reg     <= '0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_CMD_RD;
                        end
                    end
                end

                S_CMD_RD:
                begin
                    state_reg <= S_CMD_EXEC;
                end

                S_CMD_EXEC:
                begin
                    // default: single command result, back to idle
                    rv_reg      <= 1'b1;
                    kind_reg    <= KIND_CMD;
                    rtab_reg    <= tid_reg;
                    rpt_out_reg <= '0;
                    last_reg    <= 1'b1;
                    status_reg  <= STAT_OK;
                    ts_reg      <= run_reg[tix];
                    state_reg   <= S_IDLE;
                    tick_reg    <= 1'b0;
                    if (id_bad)
                    begin
                        status_reg <= STAT_BAD_ID;
                        ts_reg     <= ST_STOPPED;
                    end
                    else
                    begin
                        unique case (mode_t'(mode_reg))
                            MODE_START_REL:
                            begin
                                if (ext_reg && ((val_reg == 16'd0) ||
                                    ({1'b0, val_reg} + {1'b0, rd_data_reg} >
                                     {1'b0, cmax_reg})))
                                    status_reg <= STAT_BAD_VALUE;
                                else if (run_reg[tix] != ST_STOPPED)
                                    status_reg <= STAT_BAD_STATE;
                                else
                                begin
                                    rv_reg        <= 1'b0;
                                    run_reg[tix]  <= ST_RUNNING;
                                    cp_reg[tix]   <= '0;
                                    target_reg    <= tix;
                                    mod_start_reg <= 1'b1;
                                    mod_val_reg   <= SUM_W'(now_reg) + SUM_W'(val_reg)
                                                     + SUM_W'(rd_data_reg);
                                    state_reg     <= S_MOD_WAIT;
                                end
                            end
                            MODE_START_ABS:
                            begin
                                if (val_reg > cmax_reg)
                                    status_reg <= STAT_BAD_VALUE;
                                else if (run_reg[tix] != ST_STOPPED)
                                    status_reg <= STAT_BAD_STATE;
                                else
                                begin
                                    rv_reg        <= 1'b0;
                                    run_reg[tix]  <= ST_RUNNING;
                                    cp_reg[tix]   <= '0;
                                    target_reg    <= tix;
                                    mod_start_reg <= 1'b1;
                                    mod_val_reg   <= SUM_W'(val_reg) + SUM_W'(rd_data_reg);
                                    state_reg     <= S_MOD_WAIT;
                                end
                            end
                            MODE_STOP:
                            begin
                                if (run_reg[tix] == ST_STOPPED)
                                    status_reg <= STAT_NO_FUNC;
                                else
                                begin
                                    // drop links aimed at this table
                                    for (int k = 0; k < NUM_TABLES; k++)
                                    begin
                                        if (nv_reg[k] && (link_reg[k] == tix))
                                            nv_reg[k] <= 1'b0;
                                    end
                                    if (nv_reg[tix] && (run_reg[link_reg[tix]] == ST_NEXT))
                                        run_reg[link_reg[tix]] <= ST_STOPPED;
                                    nv_reg[tix]  <= 1'b0;
                                    run_reg[tix] <= ST_STOPPED;
                                    ts_reg       <= ST_STOPPED;
                                end
                            end
                            MODE_NEXT:
                            begin
                                if (run_reg[tix] != ST_RUNNING)
                                    status_reg <= STAT_NO_FUNC;
                                else if (run_reg[oix] != ST_STOPPED)
                                    status_reg <= STAT_BAD_STATE;
                                else
                                begin
                                    if (nv_reg[tix] && (run_reg[link_reg[tix]] == ST_NEXT))
                                        run_reg[link_reg[tix]] <= ST_STOPPED;
                                    link_reg[tix] <= oix;
                                    nv_reg[tix]   <= 1'b1;
                                    run_reg[oix]  <= ST_NEXT;
                                    cp_reg[oix]   <= '0;
                                end
                            end
                            MODE_LOAD_POINT:
                            begin
                                if ({1'b0, pidx_reg} >= 5'(MAX_POINTS))
                                    status_reg <= STAT_BAD_VALUE;
                                else if (run_reg[tix] != ST_STOPPED)
                                    status_reg <= STAT_BAD_STATE;
                            end
                            MODE_LOAD_TABLE:
                            begin
                                if ((pcnt_reg == 5'd0) || (pcnt_reg > 5'(MAX_POINTS)))
                                    status_reg <= STAT_BAD_VALUE;
                                else if (run_reg[tix] != ST_STOPPED)
                                    status_reg <= STAT_BAD_STATE;
                                else
                                begin
                                    pc_reg[tix]  <= pcnt_reg;
                                    dur_reg[tix] <= val_reg & TMASK;
                                    rpt_reg[tix] <= rep_reg;
                                end
                            end
                            default: ;  // status: report only
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (u_reg == UW'(NUM_TABLES))
                    begin
                        rv_reg      <= 1'b1;
                        kind_reg    <= KIND_TICK_DONE;
                        status_reg  <= STAT_OK;
                        rtab_reg    <= '0;
                        rpt_out_reg <= '0;
                        ts_reg      <= ST_STOPPED;
                        last_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if ((run_reg[uix] == ST_RUNNING) && (exp_reg[uix] == now_reg))
                    begin
                        i_reg     <= cp_reg[uix];
                        n_reg     <= pc_reg[uix];
                        fire_reg  <= cp_reg[uix] < pc_reg[uix];
                        tick_reg  <= 1'b1;
                        state_reg <= S_RD_A;
                    end
                    else
                    begin
                        u_reg <= u_reg + 1'b1;
                    end
                end

                S_RD_A:
                begin
                    offa_reg  <= rd_data_reg;   // offset of current point
                    state_reg <= S_RD_B;
                end

                S_RD_B:
                begin
                    target_reg <= uix;
                    if (i_inc < n_reg)
                    begin
                        cp_reg[uix]   <= i_inc;
                        mod_start_reg <= 1'b1;
                        mod_val_reg   <= SUM_W'(now_reg) + SUM_W'(delta);
                        state_reg     <= S_MOD_WAIT;
                    end
                    else if ((i_inc == n_reg) && (fin != 16'd0))
                    begin
                        // final delay before the end-of-table step
                        cp_reg[uix]   <= i_inc;
                        mod_start_reg <= 1'b1;
                        mod_val_reg   <= SUM_W'(now_reg) + SUM_W'(fin);
                        state_reg     <= S_MOD_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_RD_C;
                    end
                end

                S_RD_C:
                begin
                    // end of table: chain, repeat or stop
                    nv_reg[uix] <= 1'b0;
                    cp_reg[uix] <= '0;
                    state_reg   <= S_EMIT;
                    if (chain_ok)
                    begin
                        run_reg[link_reg[uix]] <= ST_RUNNING;
                        cp_reg[link_reg[uix]]  <= '0;
                        run_reg[uix]           <= ST_STOPPED;
                        target_reg             <= link_reg[uix];
                        mod_start_reg          <= 1'b1;
                        mod_val_reg            <= SUM_W'(now_reg) + SUM_W'(rd_data_reg);
                        state_reg              <= S_MOD_WAIT;
                    end
                    else if (rpt_reg[uix])
                    begin
                        mod_start_reg <= 1'b1;
                        mod_val_reg   <= SUM_W'(now_reg) + SUM_W'(rd_data_reg);
                        state_reg     <= S_MOD_WAIT;
                    end
                    else
                    begin
                        run_reg[uix] <= ST_STOPPED;
                    end
                end

                S_MOD_WAIT:
                begin
                    if (mod_done)
                    begin
                        exp_reg[target_reg] <= mod_res;
                        if (tick_reg)
                        begin
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            rv_reg      <= 1'b1;
                            kind_reg    <= KIND_CMD;
                            status_reg  <= STAT_OK;
                            rtab_reg    <= tid_reg;
                            rpt_out_reg <= '0;
                            ts_reg      <= run_reg[tix];
                            last_reg    <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (fire_reg)
                    begin
                        rv_reg      <= 1'b1;
                        kind_reg    <= KIND_POINT;
                        status_reg  <= STAT_OK;
                        rtab_reg    <= 4'(u_reg);
                        rpt_out_reg <= i_reg[3:0];
                        ts_reg      <= run_reg[uix];
                        last_reg    <= 1'b0;
                    end
                    u_reg     <= u_reg + 1'b1;
                    state_reg <= S_SCAN;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign result_table = rtab_reg;
    assign result_point = rpt_out_reg;
    assign table_state  = ts_reg;
    assign last         = last_reg;

    // an item's final result coincides with the return to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_tick_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_TICK_DONE) |-> last)
        else $error("tick done without last");

    a_mid_is_point: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> (kind == KIND_POINT))
        else $error("non-final result is not a point action");

endmodule

### bench/schedule_table_expiry_engine_tb.sv
// Self-checking testbench for the schedule table expiry engine.
// Depends on stee_pkg and the RTL top level schedule_table_expiry_engine.
// Directed command and tick cases, then random phases, most with sender idling.
module schedule_table_expiry_engine_tb;
    import stee_pkg::*;

    localparam int NTAB = 8;
    localparam int NPTS = 16;
    localparam int CYCLE_LIMIT = 3000000;

    // one command/tick transaction as the block sees it
    typedef struct packed {
        mode_t      mode;
        logic [3:0] tid;
        logic [3:0] oth;
        logic [15:0] val;
        logic [3:0] pidx;
        logic [4:0] pcnt;
        logic       rep;
    } sched_cmd_t;

    // one result transaction
    typedef struct packed {
        kind_t      kind;
        status_t    stat;
        logic [3:0] tbl;
        logic [3:0] pt;
        run_state_t ts;
        logic       lst;
    } sched_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] mode = '0;
    logic [3:0] table_id = '0;
    logic [3:0] other_table = '0;
    logic [15:0] value = '0;
    logic [3:0] point_index = '0;
    logic [4:0] point_count = '0;
    logic repeat_flag = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic result_valid;
    logic [1:0] kind;
    logic [2:0] status;
    logic [3:0] result_table;
    logic [3:0] result_point;
    logic [1:0] table_state;
    logic last;

    schedule_table_expiry_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .table_id(table_id), .other_table(other_table),
        .value(value), .point_index(point_index), .point_count(point_count),
        .repeat_flag(repeat_flag), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .kind(kind), .status(status), .result_table(result_table),
        .result_point(result_point), .table_state(table_state), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- scheduler model state ----------------
    logic [15:0]  cnt_max;
    logic         ext_chk;
    logic [15:0]  offs [NTAB][NPTS];
    logic [4:0]   npts [NTAB];
    logic [15:0]  dur [NTAB];
    logic         rpt [NTAB];
    run_state_t   rstate [NTAB];
    logic [4:0]   cur_pt [NTAB];
    logic [15:0]  exp_val [NTAB];
    logic [3:0]   link [NTAB];
    logic         link_ok [NTAB];
    logic [15:0]  now_cnt;

    sched_res_t expected_results [$];
    int errors = 0;
    int cycles = 0;

    // modular counter add: wraps at counter_max + 1
    function automatic logic [15:0] wrap_add(int unsigned base, int unsigned add);
        int unsigned m;
        m = int'(cnt_max) + 1;
        return 16'(((base % m) + (add % m)) % m);
    endfunction

    function automatic sched_res_t mk_res(kind_t k, status_t s, int tbl, int pt,
                                          run_state_t ts, logic lst);
        sched_res_t r;
        r.kind = k; r.stat = s; r.tbl = 4'(tbl); r.pt = 4'(pt); r.ts = ts; r.lst = lst;
        return r;
    endfunction

    // step a table past its current expiry point
    task automatic step_table(int t);
        int n;
        int i;
        int nx;
        logic at_end;
        logic [15:0] fin;
        n = npts[t];
        i = cur_pt[t];
        at_end = (i >= n);
        if (!at_end && i + 1 == n)
        begin
            fin = dur[t] - offs[t][n-1];
            if (fin != 0)
            begin
                exp_val[t] = wrap_add(now_cnt, fin);
                cur_pt[t] = 5'(i + 1);
                return;
            end
            at_end = 1'b1;
        end
        if (at_end)
        begin
            nx = link[t];
            if (link_ok[t] && nx < NTAB && rstate[nx] == ST_NEXT)
            begin
                // chained table takes over from here
                rstate[nx] = ST_RUNNING;
                cur_pt[nx] = '0;
                exp_val[nx] = wrap_add(now_cnt, offs[nx][0]);
                rstate[t] = ST_STOPPED;
            end
            else if (rpt[t])
                exp_val[t] = wrap_add(now_cnt, offs[t][0]);
            else
                rstate[t] = ST_STOPPED;
            link_ok[t] = 1'b0;
            cur_pt[t] = '0;
            return;
        end
        exp_val[t] = wrap_add(now_cnt, 16'(offs[t][i+1] - offs[t][i]));
        cur_pt[t] = 5'(i + 1);
    endtask

    // drops a chained successor that is still waiting in the next state
    task automatic drop_successor(int t);
        if (link_ok[t] && link[t] < NTAB && rstate[link[t]] == ST_NEXT)
            rstate[link[t]] = ST_STOPPED;
    endtask

    // works out the results of one accepted transaction and queues them
    task automatic predict_schedule(sched_cmd_t c);
        int t;
        int o;
        int p;
        status_t st;
        t = c.tid;
        o = c.oth;
        st = STAT_OK;
        if (c.mode == MODE_TICK)
        begin
            now_cnt = c.val;
            for (int u = 0; u < NTAB; u++)
            begin
                if (rstate[u] != ST_RUNNING || exp_val[u] != now_cnt)
                    continue;
                if (cur_pt[u] < npts[u])
                begin
                    p = cur_pt[u];
                    step_table(u);
                    expected_results.push_back(mk_res(KIND_POINT, STAT_OK, u, p,
                                                      rstate[u], 1'b0));
                end
                else
                    step_table(u);
            end
            expected_results.push_back(mk_res(KIND_TICK_DONE, STAT_OK, 0, 0,
                                              ST_STOPPED, 1'b1));
            return;
        end
        if (t >= NTAB || (c.mode == MODE_NEXT && o >= NTAB))
        begin
            expected_results.push_back(mk_res(KIND_CMD, STAT_BAD_ID, t, 0,
                                              ST_STOPPED, 1'b1));
            return;
        end
        case (c.mode)
            MODE_START_REL:
                if (ext_chk && (c.val == 0 || int'(c.val) + int'(offs[t][0]) > int'(cnt_max)))
                    st = STAT_BAD_VALUE;
                else if (rstate[t] != ST_STOPPED)
                    st = STAT_BAD_STATE;
                else
                begin
                    exp_val[t] = wrap_add(now_cnt, int'(c.val) + int'(offs[t][0]));
                    cur_pt[t] = '0;
                    rstate[t] = ST_RUNNING;
                end
            MODE_START_ABS:
                if (c.val > cnt_max)
                    st = STAT_BAD_VALUE;
                else if (rstate[t] != ST_STOPPED)
                    st = STAT_BAD_STATE;
                else
                begin
                    exp_val[t] = wrap_add(c.val, offs[t][0]);
                    cur_pt[t] = '0;
                    rstate[t] = ST_RUNNING;
                end
            MODE_STOP:
                if (rstate[t] == ST_STOPPED)
                    st = STAT_NO_FUNC;
                else
                begin
                    drop_successor(t);
                    link_ok[t] = 1'b0;
                    rstate[t] = ST_STOPPED;
                    for (int u = 0; u < NTAB; u++)
                        if (link_ok[u] && link[u] == 4'(t))
                            link_ok[u] = 1'b0;
                end
            MODE_NEXT:
                if (rstate[t] != ST_RUNNING)
                    st = STAT_NO_FUNC;
                else if (rstate[o] != ST_STOPPED)
                    st = STAT_BAD_STATE;
                else
                begin
                    drop_successor(t);
                    link[t] = 4'(o);
                    link_ok[t] = 1'b1;
                    rstate[o] = ST_NEXT;
                    cur_pt[o] = '0;
                end
            MODE_STATUS: ;
            MODE_LOAD_POINT:
                if (rstate[t] != ST_STOPPED)
                    st = STAT_BAD_STATE;
                else
                    offs[t][c.pidx] = c.val;
            default:
                if (c.pcnt == 0 || c.pcnt > NPTS)
                    st = STAT_BAD_VALUE;
                else if (rstate[t] != ST_STOPPED)
                    st = STAT_BAD_STATE;
                else
                begin
                    npts[t] = c.pcnt;
                    dur[t] = c.val;
                    rpt[t] = c.rep;
                end
        endcase
        expected_results.push_back(mk_res(KIND_CMD, st, t, 0, rstate[t], 1'b1));
    endtask

    // ---------------- result checking ----------------
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // results cannot be held off: every strobe is one transaction
    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, kind", kind, -1);
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
                if (status !== want.stat) report_mismatch("status", status, want.stat);
                if (result_table !== want.tbl)
                    report_mismatch("result_table", result_table, want.tbl);
                if (result_point !== want.pt)
                    report_mismatch("result_point", result_point, want.pt);
                if (table_state !== want.ts)
                    report_mismatch("table_state", table_state, want.ts);
                if (last !== want.lst) report_mismatch("last", last, want.lst);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------
    // sends one transaction; start stays high afterwards so back-to-back
    // items need no extra edge. Called from a posedge-aligned process.
    task automatic send_cmd(sched_cmd_t c);
        start <= 1'b1;
        mode <= c.mode;
        table_id <= c.tid;
        other_table <= c.oth;
        value <= c.val;
        point_index <= c.pidx;
        point_count <= c.pcnt;
        repeat_flag <= c.rep;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_schedule(c);
    endtask

    task automatic idle_gap(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // lowers start and waits until every queued result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic sched_cmd_t mk_cmd(mode_t m, int tid, int oth, int val,
                                          int pidx, int pcnt, logic rep);
        sched_cmd_t c;
        c.mode = m; c.tid = 4'(tid); c.oth = 4'(oth); c.val = 16'(val);
        c.pidx = 4'(pidx); c.pcnt = 5'(pcnt); c.rep = rep;
        return c;
    endfunction

    // register write, only with the engine idle
    task automatic write_reg(logic idx, logic [15:0] data);
        drain_results();
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        if (idx == CFG_COUNTER_MAX)
            cnt_max = data;
        else
            ext_chk = data[0];
    endtask

    // ---------------- tests ----------------
    // every offset gets written before any table can read it
    task automatic test_offset_preload();
        for (int t = 0; t < NTAB; t++)
            for (int p = 0; p < NPTS; p++)
                send_cmd(mk_cmd(MODE_LOAD_POINT, t, 0, 2 * p + 1, p, 1, 1'b0));
    endtask

    task automatic test_command_checks();
        send_cmd(mk_cmd(MODE_STATUS, 0, 0, 0, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_STATUS, 15, 0, 16'hFFFF, 15, 31, 1'b1));   // bad id
        send_cmd(mk_cmd(MODE_LOAD_TABLE, 0, 0, 10, 0, 0, 1'b1));        // zero points
        send_cmd(mk_cmd(MODE_LOAD_TABLE, 0, 0, 10, 0, 17, 1'b1));       // too many
        send_cmd(mk_cmd(MODE_LOAD_TABLE, 0, 0, 10, 0, 2, 1'b1));
        // final delay of zero on a repeating table
        send_cmd(mk_cmd(MODE_LOAD_TABLE, 1, 0, 1, 0, 1, 1'b1));
        send_cmd(mk_cmd(MODE_START_REL, 0, 0, 0, 0, 1, 1'b0));          // zero offset
        send_cmd(mk_cmd(MODE_START_REL, 0, 0, 16'hFFFF, 0, 1, 1'b0));   // overflows max
        send_cmd(mk_cmd(MODE_START_REL, 0, 0, 2, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_START_REL, 0, 0, 2, 0, 1, 1'b0));          // already running
        send_cmd(mk_cmd(MODE_LOAD_POINT, 0, 0, 5, 3, 1, 1'b0));         // load while running
    endtask

    task automatic test_stop_and_chain();
        send_cmd(mk_cmd(MODE_NEXT, 2, 3, 0, 0, 1, 1'b0));    // stopped source
        send_cmd(mk_cmd(MODE_NEXT, 0, 0, 0, 0, 1, 1'b0));    // target running
        send_cmd(mk_cmd(MODE_NEXT, 0, 9, 0, 0, 1, 1'b0));    // bad target id
        send_cmd(mk_cmd(MODE_NEXT, 0, 1, 0, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_STOP, 4, 0, 0, 0, 1, 1'b0));    // nothing to stop
        send_cmd(mk_cmd(MODE_START_ABS, 2, 0, 16'hFFFF, 0, 1, 1'b0)); // wraps to 0
    endtask

    // walk table 0 through its points, into the chained table 1
    task automatic test_tick_expiry();
        send_cmd(mk_cmd(MODE_TICK, 0, 0, 3, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_TICK, 0, 0, 5, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_TICK, 0, 0, 12, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_TICK, 0, 0, 13, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_TICK, 0, 0, 0, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_STOP, 1, 0, 0, 0, 1, 1'b0));
        send_cmd(mk_cmd(MODE_STOP, 2, 0, 0, 0, 1, 1'b0));
    endtask

    function automatic int pick_table();
        return ($urandom_range(9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, NTAB - 1);
    endfunction

    // mostly ticks that follow the counter or hit a pending expiry
    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t c;
        int live [$];
        int sel;
        c = mk_cmd(MODE_TICK, pick_table(), pick_table(), $urandom_range(16'hFFFF),
                   $urandom_range(15), $urandom_range(31), 1'($urandom_range(1)));
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            for (int t = 0; t < NTAB; t++)
                if (rstate[t] == ST_RUNNING) live.push_back(t);
            sel = $urandom_range(99);
            if (sel < 45)
                c.val = wrap_add(now_cnt, 1);
            else if (sel < 90 && live.size() != 0)
                c.val = exp_val[live[$urandom_range(live.size() - 1)]];
            return c;
        end
        c.mode = mode_t'($urandom_range(1, 7));
        if ($urandom_range(3) != 0)
        begin
            // well-formed values: short relative offsets, else within the counter range
            c.val = (c.mode == MODE_START_REL) ? 16'($urandom_range(1, 12))
                                               : 16'($urandom_range(int'(cnt_max)));
            c.pcnt = 5'($urandom_range(1, NPTS));
        end
        return c;
    endfunction

    task automatic test_random_phase(int n_items, int idle_pct);
        for (int i = 0; i < n_items; i++)
        begin
            if (i == n_items / 2)
                drain_results();       // sender holds until all results are in
            send_cmd(rand_cmd());
            idle_gap(idle_pct);
        end
    endtask

    // ---------------- main sequence ----------------
    initial
    begin
        cnt_max = 16'hFFFF;
        ext_chk = 1'b1;
        now_cnt = '0;
        for (int t = 0; t < NTAB; t++)
        begin
            npts[t] = 5'd1; dur[t] = '0; rpt[t] = 1'b0; rstate[t] = ST_STOPPED;
            cur_pt[t] = '0; exp_val[t] = '0; link[t] = '0; link_ok[t] = 1'b0;
            for (int p = 0; p < NPTS; p++) offs[t][p] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_offset_preload();
        test_command_checks();
        test_stop_and_chain();
        test_tick_expiry();

        write_reg(CFG_COUNTER_MAX, 16'd31);
        test_random_phase(130, 0);
        write_reg(CFG_EXT_CHECKS, 1'b0);
        write_reg(CFG_COUNTER_MAX, 16'd255);
        test_random_phase(130, 88);
        write_reg(CFG_COUNTER_MAX, 16'd1);
        write_reg(CFG_EXT_CHECKS, 1'b1);
        test_random_phase(90, 19);
        write_reg(CFG_COUNTER_MAX, 16'hFFFF);
        write_reg(CFG_EXT_CHECKS, 1'b0);
        test_random_phase(130, 19);

        drain_results();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
